@@ sv/fba_pkg.sv @@
`timescale 1ns / 1ps
package fba_pkg;

  localparam int OPCODE_W    = 2;
  localparam int ADDR_W      = 27;
  localparam int BYTES_W     = 28;
  localparam int COUNT_W     = 16;
  localparam int FRAME_SHIFT = 12;
  localparam int WORD_BITS   = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [WORD_BITS-1:0] FULL_WORD        = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]   MAX_FRAMES_RESET = 16'd32768;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_FRAMES = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FREE    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic rd;
    logic eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/fba_req_if.sv @@
`timescale 1ns / 1ps
interface fba_req_if;
  import fba_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   region_base;
  logic [BYTES_W-1:0]  region_bytes;

  modport source (output valid, output opcode, output region_base, output region_bytes,
                  input ready);
  modport sink   (input valid, input opcode, input region_base, input region_bytes,
                  output ready);
endinterface

@@ sv/fba_rsp_if.sv @@
`timescale 1ns / 1ps
interface fba_rsp_if;
  import fba_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  frame_addr;
  logic               ok;
  logic [COUNT_W-1:0] used_count;

  modport source (output valid, output frame_addr, output ok, output used_count,
                  input ready);
  modport sink   (input valid, input frame_addr, input ok, input used_count,
                  output ready);
endinterface

@@ sv/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// Operation: the block takes a request while idle and then, for each bitmap word that a region
// request touches, or that an allocation scans up to the first word with a free bit, does a
// read and a write-back; a request that touches no word goes straight to its response.
// One request is in flight at a time, the next taken once the last is finished; a finished
// request holds in its finish state while an earlier response still waits. Reset is
// synchronous: a clearing pass over every word fills the bitmap with ones first.
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 32768
) (
  input  logic                              clk,
  input  logic                              rst,
  fba_req_if.sink                           req,
  fba_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fba_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fba_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fba_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import fba_pkg::*;

  logic [COUNT_W-1:0] max_frames;
  cmd_t               cmd;
  sts_t               sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames <= MAX_FRAMES_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_FRAMES)) begin
      max_frames <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_FRAMES) begin
      prdata = APB_DATA_W'(max_frames);
    end
  end

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (req.opcode),
    .region_base  (req.region_base),
    .region_bytes (req.region_bytes),
    .max_frames   (max_frames),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .frame_addr   (rsp.frame_addr),
    .ok           (rsp.ok),
    .used_count   (rsp.used_count)
  );

endmodule

@@ sv/fba_ctrl.sv @@
`timescale 1ns / 1ps
module fba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fba_pkg::sts_t sts,
  output fba_pkg::cmd_t cmd
);
  import fba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.skip ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.walk_done ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_READ:   cmd.rd = 1'b1;
      ST_EVAL:   cmd.eval = 1'b1;
      ST_FINISH: cmd.finish = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/fba_datapath.sv @@
`timescale 1ns / 1ps
module fba_datapath #(
  parameter int NUM_FRAMES = 32768
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fba_pkg::cmd_t                 cmd,
  output fba_pkg::sts_t                 sts,
  input  logic [fba_pkg::OPCODE_W-1:0]  opcode,
  input  logic [fba_pkg::ADDR_W-1:0]    region_base,
  input  logic [fba_pkg::BYTES_W-1:0]   region_bytes,
  input  logic [fba_pkg::COUNT_W-1:0]   max_frames,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [fba_pkg::ADDR_W-1:0]    frame_addr,
  output logic                          ok,
  output logic [fba_pkg::COUNT_W-1:0]   used_count
);
  import fba_pkg::*;

  localparam int MAP_WORDS = NUM_FRAMES / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(NUM_FRAMES + 1);
  // Frame positions must hold base frame plus length, which stay below 2^17.
  localparam int PW        = (CW > 17) ? CW : 17;
  localparam int LW        = ($clog2(MAP_WORDS + 1) > 11) ? $clog2(MAP_WORDS + 1) : 11;

  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];

  logic [AW-1:0]        clr_idx;
  op_t                  op;
  logic [AW-1:0]        cur_word;
  logic [AW-1:0]        first_word;
  logic [AW-1:0]        last_word;
  logic [4:0]           lo_bit;
  logic [4:0]           hi_bit;
  logic [WORD_BITS-1:0] rdata;
  logic [5:0]           delta;
  logic                 delta_up;
  logic [CW-1:0]        used_frames;
  logic [CW-1:0]        used_next;
  logic                 res_ok;
  logic [AW+4:0]        res_frame;

  // Set-up decode from the incoming request.
  logic [PW-1:0] f0;
  logic [PW-1:0] f_end;
  logic [PW-1:0] f_end_clip;
  logic [PW-1:0] last_frame;
  logic [LW-1:0] mf_words;
  logic [LW-1:0] lim;
  logic [LW-1:0] lim_m1;
  logic          is_region;
  logic          region_empty;
  op_t           in_op;

  always_comb begin
    in_op        = op_t'(opcode);
    f0           = PW'(region_base[ADDR_W-1:FRAME_SHIFT]);
    f_end        = f0 + PW'(region_bytes[BYTES_W-1:FRAME_SHIFT]);
    f_end_clip   = (f_end > PW'(NUM_FRAMES)) ? PW'(NUM_FRAMES) : f_end;
    last_frame   = f_end_clip - PW'(1);
    region_empty = f0 >= f_end_clip;
    is_region    = (in_op == OP_FREE) || (in_op == OP_RESERVE);
    mf_words     = LW'(max_frames[COUNT_W-1:5]);
    lim          = (mf_words > LW'(MAP_WORDS)) ? LW'(MAP_WORDS) : mf_words;
    lim_m1       = lim - LW'(1);
  end

  // Word evaluation.
  logic                 is_first;
  logic                 is_last;
  logic [4:0]           lo;
  logic [4:0]           hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] flip_bits;
  logic [WORD_BITS-1:0] zero_bits;
  logic [WORD_BITS-1:0] new_word;
  logic [4:0]           zero_pos;
  logic                 found;
  logic [5:0]           flips;

  always_comb begin
    is_first  = cur_word == first_word;
    is_last   = cur_word == last_word;
    lo        = is_first ? lo_bit : 5'd0;
    hi        = is_last ? hi_bit : 5'd31;
    mask      = (FULL_WORD << lo) & (FULL_WORD >> (5'd31 - hi));
    zero_bits = ~rdata;
    found     = |zero_bits;
    zero_pos  = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (zero_bits[i]) begin
        zero_pos = 5'(i);
      end
    end
    unique case (op)
      OP_RESERVE: begin
        new_word  = rdata | mask;
        flip_bits = mask & ~rdata;
      end
      OP_FREE: begin
        new_word  = rdata & ~mask;
        flip_bits = mask & rdata;
      end
      OP_ALLOC: begin
        new_word  = rdata | (WORD_BITS'(found) << zero_pos);
        flip_bits = WORD_BITS'(found);
      end
      default: begin
        new_word  = rdata;
        flip_bits = '0;
      end
    endcase
    flips = 6'($countones(flip_bits));
  end

  always_comb begin
    used_next = delta_up ? (used_frames + CW'(delta)) : (used_frames - CW'(delta));
  end

  always_comb begin
    sts.clear_last = clr_idx == AW'(MAP_WORDS - 1);
    sts.skip       = (in_op == OP_NONE) || (is_region && region_empty) ||
                     ((in_op == OP_ALLOC) && (lim == '0));
    sts.walk_done  = is_last || ((op == OP_ALLOC) && found);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      frame_map[clr_idx] <= FULL_WORD;
    end else if (cmd.eval) begin
      frame_map[cur_word] <= new_word;
    end
    if (cmd.rd) begin
      rdata <= frame_map[cur_word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      used_frames <= CW'(NUM_FRAMES);
      delta       <= '0;
      delta_up    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_idx <= clr_idx + AW'(1);
      end
      used_frames <= used_next;
      delta       <= cmd.eval ? flips : 6'd0;
      delta_up    <= op != OP_FREE;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op         <= in_op;
      res_ok     <= is_region;
      res_frame  <= '0;
      lo_bit     <= f0[4:0];
      hi_bit     <= last_frame[4:0];
      first_word <= is_region ? f0[AW+4:5] : '0;
      cur_word   <= is_region ? f0[AW+4:5] : '0;
      last_word  <= is_region ? last_frame[AW+4:5] : lim_m1[AW-1:0];
    end else if (cmd.eval) begin
      if ((op == OP_ALLOC) && found) begin
        res_ok    <= 1'b1;
        res_frame <= {cur_word, zero_pos};
      end
      if (!sts.walk_done) begin
        cur_word <= cur_word + AW'(1);
      end
    end
    if (cmd.finish) begin
      frame_addr <= ADDR_W'({res_frame, {FRAME_SHIFT{1'b0}}});
      ok         <= res_ok;
      used_count <= COUNT_W'(used_next);
    end
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_frames <= CW'(NUM_FRAMES))
    else $error("used frame count exceeds the bitmap size");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (frame_addr == '0))
    else $error("failed request returned a non-zero frame address");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> $past(cmd.rd))
    else $error("word evaluated without a preceding read");

  a_no_flip_on_skip: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && sts.skip) |=> (delta == '0))
    else $error("count changed on a request that touches no word");

endmodule

@@ dv/frame_bitmap_allocator_test.sv @@
`timescale 1ns / 1ps
module frame_bitmap_allocator_test;
  import fba_pkg::*;

  localparam int MAP_FRAMES   = 32768;
  localparam int MAP_WORDS    = MAP_FRAMES / WORD_BITS;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 2 * MAP_WORDS + 64;
  localparam logic [APB_ADDR_W-1:0] MAX_FRAMES_ADDR = {REG_MAX_FRAMES, 2'b00};

  typedef struct packed {
    op_t                opcode;
    logic [ADDR_W-1:0]  region_base;
    logic [BYTES_W-1:0] region_bytes;
  } frame_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_addr;
    logic               ok;
    logic [COUNT_W-1:0] used_count;
  } frame_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fba_req_if req ();
  fba_rsp_if rsp ();

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic       req_valid = 1'b0;
  frame_req_t req_item  = '0;
  logic       rsp_ready = 1'b0;
  logic       rsp_hold  = 1'b0;
  bit         stall_armed = 1'b0;

  int req_idle_pct = 10;
  int rsp_idle_pct = 10;
  int req_gap      = 0;
  int rsp_gap      = 0;
  int err_count    = 0;

  assign req.valid        = req_valid;
  assign req.opcode       = req_item.opcode;
  assign req.region_base  = req_item.region_base;
  assign req.region_bytes = req_item.region_bytes;
  assign rsp.ready        = rsp_ready;

  frame_bitmap_allocator #(
    .NUM_FRAMES(MAP_FRAMES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the bitmap, the used-frame count and the frame limit.
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  int unsigned          shadow_used;
  logic [COUNT_W-1:0]   shadow_max;

  frame_req_t pending_reqs [$];
  frame_rsp_t expected_rsps [$];

  function automatic void report_fault(string what);
    err_count++;
    if (err_count <= 10)
      $display("%s", what);
  endfunction

  function automatic void set_frame_state(int unsigned frame, bit used);
    int unsigned          w;
    logic [WORD_BITS-1:0] m;
    bit                   cur;
    if (frame >= MAP_FRAMES)
      return;
    w   = frame / WORD_BITS;
    m   = 32'b1 << (frame % WORD_BITS);
    cur = (shadow_map[w] & m) != 0;
    if (used && !cur) begin
      shadow_map[w] |= m;
      shadow_used++;
    end else if (!used && cur) begin
      shadow_map[w] &= ~m;
      shadow_used--;
    end
  endfunction

  function automatic void mark_region(frame_req_t r, bit used);
    longint unsigned first_frame;
    longint unsigned n_frames;
    first_frame = r.region_base >> FRAME_SHIFT;
    n_frames    = r.region_bytes >> FRAME_SHIFT;
    for (longint unsigned f = 0; f < n_frames; f++) begin
      if (first_frame + f >= MAP_FRAMES)
        break;
      set_frame_state(int'(first_frame + f), used);
    end
  endfunction

  // Applies one request to the shadow state and returns the response it should produce.
  function automatic frame_rsp_t apply_request(frame_req_t r);
    frame_rsp_t  res;
    int unsigned n_words;
    int unsigned fr;
    bit          found;
    res   = '0;
    found = 1'b0;
    case (r.opcode)
      OP_FREE: begin
        mark_region(r, 1'b0);
        res.ok = 1'b1;
      end
      OP_RESERVE: begin
        mark_region(r, 1'b1);
        res.ok = 1'b1;
      end
      OP_ALLOC: begin
        n_words = shadow_max / WORD_BITS;
        if (n_words > MAP_WORDS)
          n_words = MAP_WORDS;
        for (int i = 0; i < n_words && !found; i++) begin
          if (shadow_map[i] != FULL_WORD) begin
            for (int j = 0; j < WORD_BITS && !found; j++) begin
              if (!shadow_map[i][j]) begin
                fr = i * WORD_BITS + j;
                set_frame_state(fr, 1'b1);
                res.frame_addr = ADDR_W'(fr << FRAME_SHIFT);
                res.ok         = 1'b1;
                found          = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.used_count = COUNT_W'(shadow_used);
    return res;
  endfunction

  function automatic void queue_req(op_t op, logic [ADDR_W-1:0] base,
                                    logic [BYTES_W-1:0] bytes);
    frame_req_t r;
    r.opcode       = op;
    r.region_base  = base;
    r.region_bytes = bytes;
    pending_reqs.push_back(r);
  endfunction

  // Most requests stay in the low part of the bitmap so that allocation finds a free
  // frame within a few words; a few reach the whole address and length range.
  function automatic frame_req_t random_request();
    frame_req_t  r;
    int unsigned pick;
    int unsigned window;
    int unsigned first;
    int unsigned len;
    pick   = $urandom_range(99);
    window = (shadow_max < 64) ? 64 : ((shadow_max > 4096) ? 4096 : shadow_max);
    r.opcode       = OP_ALLOC;
    r.region_base  = ADDR_W'($urandom);
    r.region_bytes = BYTES_W'($urandom);
    if (pick < 3) begin
      r.opcode = OP_NONE;
    end else if (pick < 4) begin
      r.opcode = $urandom_range(1) ? OP_FREE : OP_RESERVE;
    end else if (pick < 9) begin
      r.opcode = $urandom_range(1) ? OP_FREE : OP_RESERVE;
      if ($urandom_range(1)) begin
        first         = $urandom_range(MAP_FRAMES - 1, MAP_FRAMES - 8);
        r.region_base = ADDR_W'(first << FRAME_SHIFT) | ADDR_W'($urandom_range(4095));
      end
      len            = $urandom_range(8);
      r.region_bytes = BYTES_W'(len << FRAME_SHIFT) | BYTES_W'($urandom_range(4095));
    end else if (pick >= 55) begin
      r.opcode       = (pick < 80) ? OP_FREE : OP_RESERVE;
      first          = $urandom_range(window - 1);
      len            = $urandom_range(48);
      r.region_base  = ADDR_W'(first << FRAME_SHIFT) | ADDR_W'($urandom_range(4095));
      r.region_bytes = BYTES_W'(len << FRAME_SHIFT) | BYTES_W'($urandom_range(4095));
    end
    return r;
  endfunction

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // Request driver: predicts each request as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_valid && req.ready)
        expected_rsps.push_back(apply_request(req_item));
      if (!req_valid || req.ready) begin
        if (req_gap == 0 && req_idle_pct > 0 && $urandom_range(99) < req_idle_pct)
          req_gap = $urandom_range(18, 1);
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_item  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin : rsp_monitor
    frame_rsp_t want;
    frame_rsp_t got;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp.valid && rsp_ready) begin
        got.frame_addr = rsp.frame_addr;
        got.ok         = rsp.ok;
        got.used_count = rsp.used_count;
        if (expected_rsps.size() == 0) begin
          report_fault($sformatf("unexpected response: addr=%h ok=%b used=%0d",
                                 got.frame_addr, got.ok, got.used_count));
        end else begin
          want = expected_rsps.pop_front();
          if (got.frame_addr !== want.frame_addr || got.ok !== want.ok ||
              got.used_count !== want.used_count)
            report_fault($sformatf(
              "response mismatch: expected addr=%h ok=%b used=%0d, got addr=%h ok=%b used=%0d",
              want.frame_addr, want.ok, want.used_count,
              got.frame_addr, got.ok, got.used_count));
        end
      end
      if (rsp_gap == 0 && rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct)
        rsp_gap = $urandom_range(18, 1);
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !rsp_hold;
      end
    end
  end

  // Holds the response side off long enough for the block to back up its requests.
  initial begin : long_rsp_stall
    wait (stall_armed);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  task automatic wait_until_drained();
    do
      @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
  endtask

  // Writes the frame limit, then reads it back in a back-to-back transfer.
  task automatic set_max_frames(logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_FRAMES_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    shadow_max = value[COUNT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    if (prdata[COUNT_W-1:0] !== shadow_max)
      report_fault($sformatf("max_frames readback: expected %0d, got %0d",
                             shadow_max, prdata[COUNT_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [APB_DATA_W-1:0] max_value, int n_items,
                           int req_pct, int rsp_pct, bit long_stall);
    wait_until_drained();
    set_max_frames(max_value);
    @(negedge clk);
    req_idle_pct = req_pct;
    rsp_idle_pct = rsp_pct;
    if (long_stall)
      stall_armed = 1'b1;
    repeat (n_items) pending_reqs.push_back(random_request());
  endtask

  initial begin : stimulus
    for (int w = 0; w < MAP_WORDS; w++)
      shadow_map[w] = FULL_WORD;
    shadow_used = MAP_FRAMES;
    shadow_max  = MAX_FRAMES_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every frame is used after reset, so the first allocation must fail.
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_FREE, '0, '0);
    queue_req(OP_FREE, '0, 28'h0000fff);
    queue_req(OP_FREE, 27'h0001fff, 28'h0040000);
    queue_req(OP_FREE, 27'h0001000, 28'h0040000);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_RESERVE, '0, 28'h0008000);
    queue_req(OP_RESERVE, '0, 28'h0008000);
    queue_req(OP_NONE, 27'h5a5a5a5, 28'ha5a5a5a);
    // Regions running off the end of the bitmap are clipped.
    queue_req(OP_FREE, 27'h7ffffff, 28'hfffffff);
    queue_req(OP_ALLOC, 27'h7ffffff, 28'hfffffff);
    queue_req(OP_RESERVE, 27'h7fff000, 28'hfffffff);
    queue_req(OP_FREE, '0, 28'h8000000);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_RESERVE, '0, 28'h8000000);
    queue_req(OP_FREE, 27'h0000fff, 28'h0001fff);

    // Limits below one whole word leave nothing to search.
    run_phase(32'd0, 0, 10, 10, 1'b0);
    queue_req(OP_ALLOC, '0, '0);
    run_phase(32'd31, 0, 10, 10, 1'b0);
    queue_req(OP_ALLOC, '0, '0);
    run_phase(32'd32, 0, 10, 10, 1'b0);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_ALLOC, '0, '0);
    // A limit beyond the bitmap is clipped; the top frame gives the widest address.
    run_phase(32'h0000ffff, 0, 10, 10, 1'b0);
    queue_req(OP_FREE, 27'h7fff000, 28'h0001000);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_ALLOC, '0, '0);

    run_phase(32'd1024, 200, 20, 20, 1'b0);
    run_phase(32'd64, 150, 50, 5, 1'b0);
    run_phase(32'd32768, 150, 5, 50, 1'b0);
    run_phase(32'd2048, 60, 0, 0, 1'b1);
    run_phase({16'($urandom), 16'hffff}, 150, 20, 0, 1'b0);
    run_phase(32'd16, 60, 10, 10, 1'b0);
    run_phase(32'($urandom_range(8192, 32)), 200, $urandom_range(40), $urandom_range(40),
              1'b0);
    run_phase(32'd512, 200, 0, 20, 1'b0);
    run_phase(32'd4096, 200, 20, 20, 1'b0);
    // Closing stretch runs at full rate on both sides.
    run_phase(32'd1024, 350, 0, 0, 1'b0);

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_rsps.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Allows for the worst case, every request scanning the whole bitmap with the longest
  // gaps on both sides, several times over.
  initial begin : watchdog
    #(60_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
